// ----- rtl/dhh_pkg.sv -----
// ----------------------------------------------------------------------------
// dhh_pkg
// Shared types and constants of the detector hit histogrammer.
// ----------------------------------------------------------------------------
package dhh_pkg;

    localparam int STRIP_BINS = 1024;
    localparam int ADC_BINS   = 4096;
    localparam int BIN_W      = 32;

    localparam int STRIP_W = $clog2(STRIP_BINS);
    localparam int ADC_W   = $clog2(ADC_BINS);
    localparam int SWP_BINS = (ADC_BINS > STRIP_BINS) ? ADC_BINS : STRIP_BINS;
    localparam int SWP_W    = $clog2(SWP_BINS);

    localparam int OPCODE_W = 2;
    localparam int STRIP_FW = 10;
    localparam int ADC_FW   = 12;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 32;
    localparam int DSHIFT_W = 6;
    localparam logic [DSHIFT_W-1:0] DSHIFT_MAX = DSHIFT_W'(32);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    typedef enum logic [OPCODE_W-1:0] {
        OP_X_HIT   = 2'd0,
        OP_Y_HIT   = 2'd1,
        OP_CLUSTER = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic wr;
        logic sweep;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_clear;
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/dhh_ram.sv -----
// ----------------------------------------------------------------------------
// dhh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dhh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dhh_ctrl.sv -----
// ----------------------------------------------------------------------------
// dhh_ctrl
// Sequencer: clearing sweep, read-modify-write of the bins, result hand-off.
// ----------------------------------------------------------------------------
module dhh_ctrl
    import dhh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_clr_item, n_clr_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_item = r_clr_item;
        unique case (r_state)
            S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state    = r_clr_item ? S_DONE : S_IDLE;
                    n_clr_item = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_clear) begin
                        n_state    = S_SWEEP;
                        n_clr_item = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_SWEEP: o_cmd.sweep = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ:  o_cmd = '0;
            S_WRITE: o_cmd.wr = 1'b1;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_sweep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && !i_sts.sweep_last) |=> (r_state == S_SWEEP))
        else $error("sweep left early");

    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_sts.in_clear)
        |=> (r_state == S_READ) ##1 (r_state == S_WRITE) ##1 (r_state == S_DONE))
        else $error("bin update sequence broken");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("result hand-off stuck");

endmodule

// ----- rtl/dhh_datapath.sv -----
// ----------------------------------------------------------------------------
// dhh_datapath
// Item registers, bin RAMs, counters, downshift register and result register.
// ----------------------------------------------------------------------------
module dhh_datapath
    import dhh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [STRIP_FW-1:0]   i_strip,
    input  logic [ADC_FW-1:0]     i_adc,
    input  logic [SUM_W-1:0]      i_cluster_sum,
    input  logic                  i_cfg_we,
    input  logic [DSHIFT_W-1:0]   i_cfg_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [M_TDATA_W-1:0]  o_out_data
);

    t_op                 r_op;
    logic                r_ok;
    logic                r_drop;
    logic [STRIP_W-1:0]  r_strip;
    logic [ADC_W-1:0]    r_adc;
    logic [ADC_W-1:0]    r_cidx;
    logic [DSHIFT_W-1:0] r_dshift;
    logic [CNT_W-1:0]    r_hits;
    logic [CNT_W-1:0]    r_clusters;
    logic [SWP_W-1:0]    r_swp, n_swp;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    t_op              in_op;
    logic [31:0]      strip_ext;
    logic [31:0]      adc_ext;
    logic [SUM_W-1:0] cidx;
    logic             hit_ok;
    logic             clu_ok;
    logic             sum_nz;
    logic             swp_last;
    logic             sw_strip;
    logic             sw_adc;
    logic             empty;

    logic [BIN_W-1:0]     xs_rd, ys_rd, xa_rd, ya_rd, cl_rd;
    logic                 xs_we, ys_we, xa_we, ya_we, cl_we;
    logic [STRIP_W-1:0]   strip_waddr;
    logic [ADC_W-1:0]     adc_waddr;
    logic [ADC_W-1:0]     cl_waddr;
    logic [BIN_W-1:0]     xs_wd, ys_wd, xa_wd, ya_wd, cl_wd;

    assign in_op     = t_op'(i_opcode);
    assign strip_ext = 32'(i_strip);
    assign adc_ext   = 32'(i_adc);
    assign cidx      = (i_cluster_sum == '0 || r_dshift >= DSHIFT_MAX) ? '0
                       : (i_cluster_sum >> r_dshift);
    assign sum_nz    = (i_cluster_sum != '0);
    assign hit_ok    = (strip_ext < 32'(STRIP_BINS)) && (adc_ext < 32'(ADC_BINS));
    assign clu_ok    = sum_nz && (cidx < 32'(ADC_BINS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= in_op;
            r_strip <= strip_ext[STRIP_W-1:0];
            r_adc   <= adc_ext[ADC_W-1:0];
            r_cidx  <= cidx[ADC_W-1:0];
            unique case (in_op)
                OP_X_HIT, OP_Y_HIT: begin
                    r_ok   <= hit_ok;
                    r_drop <= !hit_ok;
                end
                OP_CLUSTER: begin
                    r_ok   <= clu_ok;
                    r_drop <= sum_nz && !clu_ok;
                end
                default: begin
                    r_ok   <= 1'b0;
                    r_drop <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dshift <= '0;
        end else if (i_cfg_we) begin
            r_dshift <= (i_cfg_wdata > DSHIFT_MAX) ? DSHIFT_MAX : i_cfg_wdata;
        end
    end

    assign swp_last = (r_swp == SWP_W'(SWP_BINS - 1));
    assign n_swp    = swp_last ? '0 : r_swp + SWP_W'(1);
    assign sw_strip = ({1'b0, r_swp} < (SWP_W + 1)'(STRIP_BINS));
    assign sw_adc   = ({1'b0, r_swp} < (SWP_W + 1)'(ADC_BINS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp <= '0;
        end else if (i_cmd.sweep) begin
            r_swp <= n_swp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sweep) begin
            r_hits     <= '0;
            r_clusters <= '0;
        end else if (i_cmd.wr && r_ok) begin
            if (r_op == OP_X_HIT || r_op == OP_Y_HIT) begin
                r_hits <= r_hits + CNT_W'(1);
            end else if (r_op == OP_CLUSTER) begin
                r_clusters <= r_clusters + CNT_W'(1);
            end
        end
    end

    assign strip_waddr = i_cmd.sweep ? r_swp[STRIP_W-1:0] : r_strip;
    assign adc_waddr   = i_cmd.sweep ? r_swp[ADC_W-1:0] : r_adc;
    assign cl_waddr    = i_cmd.sweep ? r_swp[ADC_W-1:0] : r_cidx;

    assign xs_we = (i_cmd.sweep && sw_strip) || (i_cmd.wr && r_ok && r_op == OP_X_HIT);
    assign ys_we = (i_cmd.sweep && sw_strip) || (i_cmd.wr && r_ok && r_op == OP_Y_HIT);
    assign xa_we = (i_cmd.sweep && sw_adc) || (i_cmd.wr && r_ok && r_op == OP_X_HIT);
    assign ya_we = (i_cmd.sweep && sw_adc) || (i_cmd.wr && r_ok && r_op == OP_Y_HIT);
    assign cl_we = (i_cmd.sweep && sw_adc) || (i_cmd.wr && r_ok && r_op == OP_CLUSTER);

    assign xs_wd = i_cmd.sweep ? '0 : xs_rd + BIN_W'(1);
    assign ys_wd = i_cmd.sweep ? '0 : ys_rd + BIN_W'(1);
    assign xa_wd = i_cmd.sweep ? '0 : xa_rd + BIN_W'(1);
    assign ya_wd = i_cmd.sweep ? '0 : ya_rd + BIN_W'(1);
    assign cl_wd = i_cmd.sweep ? '0 : cl_rd + BIN_W'(1);

    dhh_ram #(.WIDTH(BIN_W), .DEPTH(STRIP_BINS)) u_x_strip (
        .i_clk(i_clk), .i_we(xs_we), .i_waddr(strip_waddr), .i_wdata(xs_wd),
        .i_raddr(r_strip), .o_rdata(xs_rd)
    );

    dhh_ram #(.WIDTH(BIN_W), .DEPTH(STRIP_BINS)) u_y_strip (
        .i_clk(i_clk), .i_we(ys_we), .i_waddr(strip_waddr), .i_wdata(ys_wd),
        .i_raddr(r_strip), .o_rdata(ys_rd)
    );

    dhh_ram #(.WIDTH(BIN_W), .DEPTH(ADC_BINS)) u_x_adc (
        .i_clk(i_clk), .i_we(xa_we), .i_waddr(adc_waddr), .i_wdata(xa_wd),
        .i_raddr(r_adc), .o_rdata(xa_rd)
    );

    dhh_ram #(.WIDTH(BIN_W), .DEPTH(ADC_BINS)) u_y_adc (
        .i_clk(i_clk), .i_we(ya_we), .i_waddr(adc_waddr), .i_wdata(ya_wd),
        .i_raddr(r_adc), .o_rdata(ya_rd)
    );

    dhh_ram #(.WIDTH(BIN_W), .DEPTH(ADC_BINS)) u_cluster (
        .i_clk(i_clk), .i_we(cl_we), .i_waddr(cl_waddr), .i_wdata(cl_wd),
        .i_raddr(r_cidx), .o_rdata(cl_rd)
    );

    assign empty = (r_hits == '0) && (r_clusters == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {(M_TDATA_W - 2 * CNT_W - 2)'(0), r_drop, empty,
                           r_clusters, r_hits};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.in_clear   = (in_op == OP_CLEAR);
    assign o_sts.sweep_last = swp_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_ok && (r_op == OP_X_HIT || r_op == OP_Y_HIT))
        |=> (r_hits == $past(r_hits) + CNT_W'(1)))
        else $error("hit counter not advanced");

    a_sweep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |=> (r_hits == '0 && r_clusters == '0))
        else $error("counters not cleared by sweep");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2*CNT_W] ==
                         (r_out_data[CNT_W-1:0] == '0 && r_out_data[2*CNT_W-1:CNT_W] == '0)))
        else $error("empty flag inconsistent with totals");

endmodule

// ----- rtl/detector_hit_histogrammer_core.sv -----
// ----------------------------------------------------------------------------
// detector_hit_histogrammer_core
// Histogrammer for a two-axis strip detector: strip, ADC and cluster bins.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel; tuser carries the opcode (x hit, y hit,
//   cluster sum, clear). Each item gives one result on m_axis with the hit
//   and cluster totals after the item, an empty flag and a dropped flag.
//   i_cfg_we writes the cluster downshift (values above 32 are held as 32);
//   write it only while no transaction is in flight.
//   Hit and cluster items: one read-modify-write of the bin RAMs (states READ,
//   WRITE, DONE); a new item is taken only after the result is loaded.
//   The registered RAM read makes the READ state necessary.
//   Clear items: a zeroing sweep over all bin RAMs, one address per cycle;
//   the result is loaded once the sweep has ended and the register is free.
//   Reset: the same sweep runs; s_axis_tready stays low until done.
//   Stall: a result waits in the output register; one further item is
//   accepted and processed, then holds until the register frees.
// ----------------------------------------------------------------------------
module detector_hit_histogrammer_core
    import dhh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // strip[9:0], adc[21:10], cluster_sum[53:22]
    input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // hits_total[31:0], clusters_total[63:32],
                                                 // empty_res[64], dropped[65]
    input  logic                  i_cfg_we,
    input  logic [DSHIFT_W-1:0]   i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    dhh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dhh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (s_axis_tuser),
        .i_strip       (s_axis_tdata[STRIP_FW-1:0]),
        .i_adc         (s_axis_tdata[STRIP_FW+ADC_FW-1:STRIP_FW]),
        .i_cluster_sum (s_axis_tdata[STRIP_FW+ADC_FW+SUM_W-1:STRIP_FW+ADC_FW]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata)
    );

endmodule

// ----- verif/detector_hit_histogrammer_core_tb.sv -----
// ----------------------------------------------------------------------------
// detector_hit_histogrammer_core_tb
// Self-checking bench for the strip detector histogrammer. A driver streams
// hit, cluster and clear transactions while a predictor tracks the hit and
// cluster totals, the empty flag and the dropped flag per transaction. A
// monitor compares every result in order. Random backpressure runs on both
// sides. The cluster downshift is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module detector_hit_histogrammer_core_tb;
    import dhh_pkg::*;

    localparam int PHASE_ITEMS = 120;

    typedef struct packed {
        t_op                op;
        logic [STRIP_FW-1:0] strip;
        logic [ADC_FW-1:0]   adc;
        logic [SUM_W-1:0]    sum;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] clusters;
        logic             empty;
        logic             dropped;
    } t_tally;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // strip[9:0], adc[21:10], cluster_sum[53:22]
    logic [OPCODE_W-1:0]  s_axis_tuser = '0;  // opcode[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // hits_total[31:0], clusters_total[63:32],
                                              // empty_res[64], dropped[65]
    logic                 i_cfg_we = 1'b0;
    logic [DSHIFT_W-1:0]  i_cfg_wdata = '0;

    t_item       feed_q[$];
    t_tally      tally_q[$];
    t_item       cur_item;
    t_tally      want;
    t_tally      got;
    logic [31:0] exp_hits;
    logic [31:0] exp_clusters;
    int unsigned downshift;
    int unsigned n_sent;
    int unsigned n_seen;
    int unsigned n_fail;

    detector_hit_histogrammer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // expected totals after one transaction; updates the tracked counters
    function automatic t_tally tally_item(t_item it);
        t_tally      t;
        logic [31:0] idx;
        t.dropped = 1'b0;
        case (it.op)
            OP_X_HIT, OP_Y_HIT: begin
                if (32'(it.strip) >= STRIP_BINS || 32'(it.adc) >= ADC_BINS) begin
                    t.dropped = 1'b1;
                end else begin
                    exp_hits = exp_hits + 1;
                end
            end
            OP_CLUSTER: begin
                if (it.sum != '0) begin
                    idx = (downshift >= 32) ? 32'd0 : (it.sum >> downshift);
                    if (idx >= ADC_BINS) begin
                        t.dropped = 1'b1;
                    end else begin
                        exp_clusters = exp_clusters + 1;
                    end
                end
            end
            default: begin
                exp_hits     = '0;
                exp_clusters = '0;
            end
        endcase
        t.hits     = exp_hits;
        t.clusters = exp_clusters;
        t.empty    = (exp_hits == 0 && exp_clusters == 0);
        return t;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                tally_q.push_back(tally_item(cur_item));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (feed_q.size() != 0 &&
                    ((n_sent >= 500 && n_sent < 700) || $urandom_range(0, 99) >= 8)) begin
                    cur_item = feed_q.pop_front();
                    s_axis_tdata  <= {2'b00, cur_item.sum, cur_item.adc, cur_item.strip};
                    s_axis_tuser  <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_seen++;
                got.hits     = m_axis_tdata[31:0];
                got.clusters = m_axis_tdata[63:32];
                got.empty    = m_axis_tdata[64];
                got.dropped  = m_axis_tdata[65];
                if (tally_q.size() == 0) begin
                    $error("unexpected result transaction: %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = tally_q.pop_front();
                    if (got.hits !== want.hits) begin
                        $error("hits_total: expected %0d, got %0d", want.hits, got.hits);
                        n_fail++;
                    end
                    if (got.clusters !== want.clusters) begin
                        $error("clusters_total: expected %0d, got %0d",
                               want.clusters, got.clusters);
                        n_fail++;
                    end
                    if (got.empty !== want.empty) begin
                        $error("empty_res: expected %0b, got %0b", want.empty, got.empty);
                        n_fail++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                        n_fail++;
                    end
                end
            end
            m_axis_tready <= (n_seen >= 500 && n_seen < 700) || $urandom_range(0, 99) >= 8;
        end
    end

    task automatic push_item(t_op op, logic [STRIP_FW-1:0] strip, logic [ADC_FW-1:0] adc,
                             logic [SUM_W-1:0] sum);
        t_item it;
        it.op    = op;
        it.strip = strip;
        it.adc   = adc;
        it.sum   = sum;
        feed_q.push_back(it);
    endtask

    // checked mid-cycle so that the edge's updates have settled
    task automatic drain();
        @(negedge i_clk);
        while (feed_q.size() != 0 || s_axis_tvalid || tally_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_downshift(logic [DSHIFT_W-1:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        downshift = (v > DSHIFT_MAX) ? 32 : v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned r;
        int unsigned idx;
        logic [SUM_W-1:0] sum;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 999);
            if (r < 400) begin
                push_item(OP_X_HIT, STRIP_FW'($urandom), ADC_FW'($urandom), $urandom);
            end else if (r < 750) begin
                push_item(OP_Y_HIT, STRIP_FW'($urandom), ADC_FW'($urandom), $urandom);
            end else if (r < 985) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    sum = '0;
                end else if (r < 45) begin
                    sum = $urandom;
                end else if (downshift >= 32) begin
                    sum = $urandom | 32'd1;
                end else begin
                    idx = $urandom_range(0, ADC_BINS - 1);
                    sum = 32'((64'(idx) << downshift) |
                              (64'($urandom) & ((64'd1 << downshift) - 1)));
                end
                push_item(OP_CLUSTER, STRIP_FW'($urandom), ADC_FW'($urandom), sum);
            end else begin
                push_item(OP_CLEAR, STRIP_FW'($urandom), ADC_FW'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        logic [DSHIFT_W-1:0] shifts[10];
        shifts = '{6'd0, 6'd63, 6'd20, 6'd32, 6'd33, 6'd7, 6'd12, 6'd26, 6'd1, 6'd0};
        exp_hits      = '0;
        exp_clusters  = '0;
        downshift     = 0;
        n_sent        = 0;
        n_seen        = 0;
        n_fail        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, no shift
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd0);
        push_item(OP_X_HIT, 10'd0, 12'd0, 32'd0);
        push_item(OP_X_HIT, 10'd1023, 12'd4095, 32'hFFFF_FFFF);
        push_item(OP_Y_HIT, 10'd0, 12'd4095, 32'd0);
        push_item(OP_Y_HIT, 10'd1023, 12'd0, 32'd0);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd1);
        push_item(OP_CLUSTER, 10'd1023, 12'd4095, 32'd4095);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd4096);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'hFFFF_FFFF);
        push_item(OP_CLEAR, 10'd1023, 12'd4095, 32'hFFFF_FFFF);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd0);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd4095);
        push_item(OP_X_HIT, 10'h2AA, 12'h555, 32'hAAAA_5555);
        set_downshift(6'd32);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'hFFFF_FFFF);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'd1);
        set_downshift(6'd63);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'h8000_0000);
        set_downshift(6'd20);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'hFFFF_FFFF);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'h0010_0000);
        set_downshift(6'd19);
        push_item(OP_CLUSTER, 10'd0, 12'd0, 32'hFFFF_FFFF);
        push_item(OP_Y_HIT, 10'h155, 12'hAAA, 32'h5555_AAAA);
        push_item(OP_CLEAR, 10'd0, 12'd0, 32'd0);

        foreach (shifts[k]) begin
            set_downshift(shifts[k]);
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #24_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
